// File: rtl/core/bfu_pkg.sv
// ----------------------------------------------------------------------------
// bfu_pkg
// Shared constants and types for the battery filter and undervoltage lockout.
// ----------------------------------------------------------------------------
package bfu_pkg;

  localparam int SAMPLE_BITS_DEFAULT  = 10;
  localparam int GAIN_SHIFT_DEFAULT   = 11;
  localparam int COUNTER_BITS_DEFAULT = 14;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  localparam int DEC_INTERVAL_RESET  = 9345;
  localparam int LOCKOUT_THR_RESET   = 263;
  localparam int NO_BATTERY_THR_RESET = 169;
  localparam int KEEP_GAIN_RESET     = 1843;
  localparam int ADD_GAIN_RESET      = 204;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DEC_INTERVAL   = 3'd0,
    REG_LOCKOUT_THR    = 3'd1,
    REG_NO_BATTERY_THR = 3'd2,
    REG_KEEP_GAIN      = 3'd3,
    REG_ADD_GAIN       = 3'd4
  } cfg_reg_t;

endpackage

// File: rtl/core/bfu_if.sv
// ----------------------------------------------------------------------------
// bfu channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface bfu_sample_if #(
  parameter int SAMPLE_BITS = bfu_pkg::SAMPLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] battery_sample;

  modport source (output valid, output battery_sample, input ready);
  modport sink   (input valid, input battery_sample, output ready);
endinterface

interface bfu_result_if #(
  parameter int SAMPLE_BITS = bfu_pkg::SAMPLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered_voltage;
  logic [SAMPLE_BITS-1:0] decimated_voltage;
  logic                   decimation_strobe;
  logic                   lockout;

  modport source (output valid, output filtered_voltage, output decimated_voltage,
                  output decimation_strobe, output lockout, input ready);
  modport sink   (input valid, input filtered_voltage, input decimated_voltage,
                  input decimation_strobe, input lockout, output ready);
endinterface

interface bfu_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bfu_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [bfu_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/bfu_filter.sv
// ----------------------------------------------------------------------------
// bfu_filter
// Fixed-point exponential average update with saturation.
// ----------------------------------------------------------------------------
module bfu_filter #(
  parameter int SAMPLE_BITS = bfu_pkg::SAMPLE_BITS_DEFAULT,
  parameter int GAIN_SHIFT  = bfu_pkg::GAIN_SHIFT_DEFAULT
) (
  input  logic [SAMPLE_BITS-1:0] average,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [GAIN_SHIFT-1:0]  keep_gain,
  input  logic [GAIN_SHIFT-1:0]  add_gain,
  output logic [SAMPLE_BITS-1:0] filtered
);

  localparam int PROD_BITS = SAMPLE_BITS + GAIN_SHIFT;
  localparam int SUM_BITS  = PROD_BITS + 1;

  logic [PROD_BITS-1:0]     keep_prod;
  logic [PROD_BITS-1:0]     add_prod;
  logic [SUM_BITS-1:0]      sum;
  logic [SAMPLE_BITS:0]     scaled;

  assign keep_prod = PROD_BITS'(average) * PROD_BITS'(keep_gain);
  assign add_prod  = PROD_BITS'(sample) * PROD_BITS'(add_gain);
  assign sum       = SUM_BITS'(keep_prod) + SUM_BITS'(add_prod);
  assign scaled    = sum[SUM_BITS-1:GAIN_SHIFT];
  assign filtered  = scaled[SAMPLE_BITS] ? {SAMPLE_BITS{1'b1}} : scaled[SAMPLE_BITS-1:0];

endmodule

// File: rtl/core/battery_filter_undervoltage_lockout.sv
// ----------------------------------------------------------------------------
// battery_filter_undervoltage_lockout
// Exponential average of battery samples, decimation and latched lockout.
// ----------------------------------------------------------------------------
// channel  modport  payload
// sample   sink     battery_sample
// result   source   filtered_voltage, decimated_voltage, decimation_strobe, lockout
// cfg      sink     index, data (always ready)
//
// One item per cycle sustained while result is not stalled. An accepted sample sits
// in the input register, then the filter update lands in the result register together
// with result valid.
// rst clears the pipeline, the filter state and restores register defaults.
// A stalled result holds the pipeline; one item waits in the input register.
// ----------------------------------------------------------------------------
module battery_filter_undervoltage_lockout #(
  parameter int SAMPLE_BITS  = bfu_pkg::SAMPLE_BITS_DEFAULT,
  parameter int GAIN_SHIFT   = bfu_pkg::GAIN_SHIFT_DEFAULT,
  parameter int COUNTER_BITS = bfu_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  bfu_sample_if.sink   sample,
  bfu_result_if.source result,
  bfu_cfg_if.sink      cfg
);

  logic [COUNTER_BITS-1:0] dec_interval;
  logic [SAMPLE_BITS-1:0]  lockout_thr;
  logic [SAMPLE_BITS-1:0]  no_battery_thr;
  logic [GAIN_SHIFT-1:0]   keep_gain;
  logic [GAIN_SHIFT-1:0]   add_gain;

  logic                    in_valid;
  logic [SAMPLE_BITS-1:0]  in_sample;

  logic [SAMPLE_BITS-1:0]  average;
  logic [SAMPLE_BITS-1:0]  current_dec;
  logic [SAMPLE_BITS-1:0]  previous_dec;
  logic [COUNTER_BITS-1:0] counter;
  logic                    seeded;
  logic                    lockout;

  logic                    out_valid;
  logic [SAMPLE_BITS-1:0]  out_filtered;
  logic [SAMPLE_BITS-1:0]  out_decimated;
  logic                    out_strobe;

  logic                    advance;
  logic [SAMPLE_BITS-1:0]  filter_out;
  logic [SAMPLE_BITS-1:0]  average_next;
  logic [SAMPLE_BITS-1:0]  current_next;
  logic [SAMPLE_BITS-1:0]  previous_next;
  logic [COUNTER_BITS-1:0] counter_next;
  logic [COUNTER_BITS:0]   count_inc;
  logic [SAMPLE_BITS-1:0]  current_seed;
  logic                    strobe_next;
  logic                    lockout_next;

  assign cfg.ready    = 1'b1;
  assign advance      = !out_valid || result.ready;
  assign sample.ready = !in_valid || advance;

  assign result.valid             = out_valid;
  assign result.filtered_voltage  = out_filtered;
  assign result.decimated_voltage = out_decimated;
  assign result.decimation_strobe = out_strobe;
  assign result.lockout           = lockout;

  bfu_filter #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .GAIN_SHIFT  (GAIN_SHIFT)
  ) u_filter (
    .average   (average),
    .sample    (in_sample),
    .keep_gain (keep_gain),
    .add_gain  (add_gain),
    .filtered  (filter_out)
  );

  always_comb begin
    average_next  = seeded ? filter_out : in_sample;
    current_seed  = seeded ? current_dec : in_sample;
    count_inc     = {1'b0, counter} + {{COUNTER_BITS{1'b0}}, 1'b1};
    strobe_next   = count_inc > {1'b0, dec_interval};
    current_next  = current_seed;
    previous_next = seeded ? previous_dec : in_sample;
    counter_next  = count_inc[COUNTER_BITS-1:0];
    lockout_next  = lockout;
    if (strobe_next) begin
      counter_next  = '0;
      previous_next = current_seed;
      current_next  = average_next;
      if (average_next <= lockout_thr && current_seed <= lockout_thr &&
          in_sample > no_battery_thr) begin
        lockout_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_interval   <= COUNTER_BITS'(bfu_pkg::DEC_INTERVAL_RESET);
      lockout_thr    <= SAMPLE_BITS'(bfu_pkg::LOCKOUT_THR_RESET);
      no_battery_thr <= SAMPLE_BITS'(bfu_pkg::NO_BATTERY_THR_RESET);
      keep_gain      <= GAIN_SHIFT'(bfu_pkg::KEEP_GAIN_RESET);
      add_gain       <= GAIN_SHIFT'(bfu_pkg::ADD_GAIN_RESET);
    end else if (cfg.valid) begin
      unique case (bfu_pkg::cfg_reg_t'(cfg.index))
        bfu_pkg::REG_DEC_INTERVAL:   dec_interval   <= cfg.data[COUNTER_BITS-1:0];
        bfu_pkg::REG_LOCKOUT_THR:    lockout_thr    <= cfg.data[SAMPLE_BITS-1:0];
        bfu_pkg::REG_NO_BATTERY_THR: no_battery_thr <= cfg.data[SAMPLE_BITS-1:0];
        bfu_pkg::REG_KEEP_GAIN:      keep_gain      <= cfg.data[GAIN_SHIFT-1:0];
        bfu_pkg::REG_ADD_GAIN:       add_gain       <= cfg.data[GAIN_SHIFT-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      average      <= '0;
      current_dec  <= '0;
      previous_dec <= '0;
      counter      <= '0;
      seeded       <= 1'b0;
      lockout      <= 1'b0;
    end else begin
      if (sample.valid && sample.ready) begin
        in_valid  <= 1'b1;
        in_sample <= sample.battery_sample;
      end else if (advance) begin
        in_valid  <= 1'b0;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (in_valid && advance) begin
        average       <= average_next;
        current_dec   <= current_next;
        previous_dec  <= previous_next;
        counter       <= counter_next;
        seeded        <= 1'b1;
        lockout       <= lockout_next;
        out_filtered  <= average_next;
        out_decimated <= current_next;
        out_strobe    <= strobe_next;
      end
    end
  end

endmodule

// File: rtl/core/bfu_checker.sv
// ----------------------------------------------------------------------------
// bfu_checker
// Port-level checks on results of the battery filter, bound to the top level.
// ----------------------------------------------------------------------------
module bfu_checker #(
  parameter int SAMPLE_BITS = bfu_pkg::SAMPLE_BITS_DEFAULT
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   res_valid,
  input logic                   res_ready,
  input logic [SAMPLE_BITS-1:0] filtered_voltage,
  input logic [SAMPLE_BITS-1:0] decimated_voltage,
  input logic                   decimation_strobe,
  input logic                   lockout
);

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid straight after reset");

  a_lockout_sticky: assert property (@(posedge clk) disable iff (rst)
    res_valid && lockout |=> !res_valid || lockout)
    else $error("lockout dropped without reset");

  a_strobe_takes_filtered: assert property (@(posedge clk) disable iff (rst)
    res_valid && decimation_strobe |-> decimated_voltage == filtered_voltage)
    else $error("decimated value differs from filtered value on strobe");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(filtered_voltage) &&
      $stable(decimated_voltage) && $stable(decimation_strobe))
    else $error("stalled item changed");

endmodule

bind battery_filter_undervoltage_lockout bfu_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bfu_checker (
  .clk               (clk),
  .rst               (rst),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .filtered_voltage  (result.filtered_voltage),
  .decimated_voltage (result.decimated_voltage),
  .decimation_strobe (result.decimation_strobe),
  .lockout           (result.lockout)
);
